@@ hdl/quaternion_vector_rotation_assert.svh @@
// Assertion macros used by the rotation block.
`ifndef QUATERNION_VECTOR_ROTATION_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATION_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define QVR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Rotation block assertion failed.");

// The consequent holds in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Rotation block assertion failed.");

`endif

@@ hdl/qvr_pkg.sv @@
package qvr_pkg;

  localparam int VecWidth     = 32;
  localparam int QuatWidth    = 16;
  localparam int QuatFracBits = 14;

  typedef struct packed {
    logic signed [VecWidth-1:0]  vec_x;
    logic signed [VecWidth-1:0]  vec_y;
    logic signed [VecWidth-1:0]  vec_z;
    logic signed [QuatWidth-1:0] quat_w;
    logic signed [QuatWidth-1:0] quat_x;
    logic signed [QuatWidth-1:0] quat_y;
    logic signed [QuatWidth-1:0] quat_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [VecWidth-1:0] rot_x;
    logic signed [VecWidth-1:0] rot_y;
    logic signed [VecWidth-1:0] rot_z;
    logic                       saturated;
  } qvr_out_t;

endpackage

@@ hdl/quaternion_vector_rotation.sv @@
// Rotates a vector by a fixed-point quaternion, one item per clock.
// Input channel: cmd_i carries the vector and the quaternion; an item is
// accepted at a rising edge where start_i is high and busy_o is low. busy_o
// is held low, so an item may be started in every cycle.
// Output channel: result_o carries the rotated vector and the saturation
// flag; it is valid for the single cycle in which done_o is high.
// An accepted item passes through p1_q, t_q, p2_q, r_q and out_q in that order,
// with its valid bit in vld_q beside it, before it appears on result_o.
// Throughput is one item per cycle.
// The five register stages are the first quaternion products, the sums for
// t, the second quaternion products, the final sums, and the clamp into the
// output register; the 16-bit by vector-width multipliers set the depth.
// A zero vector gives a zero result, and the identity quaternion passes the
// vector through unchanged, both without saturation.
// Reset clears the valid bits of every stage, so items in flight are
// dropped and done_o stays low until a new item has passed through.
// The receiver cannot stall: every result is shown once and must be taken.
`include "quaternion_vector_rotation_assert.svh"

module quaternion_vector_rotation import qvr_pkg::*; #(
  parameter int QUAT_FRAC_BITS = QuatFracBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  qvr_in_t  cmd_i,
  output logic     done_o,
  output qvr_out_t result_o
);

  localparam int VW    = VecWidth;
  localparam int QW    = QuatWidth;
  localparam int F     = QUAT_FRAC_BITS;
  localparam int P1W   = VW + QW;
  localparam int TBase = (VW + QW - F > 2) ? (VW + QW - F) : 2;
  localparam int TW    = TBase + 2;
  localparam int P2W   = QW + TW;
  localparam int RW    = P2W + 3;

  localparam logic signed [32:0]   QOne = 33'sd1 <<< F;
  localparam logic signed [RW-1:0] RMax = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [RW-1:0] RMin = {{(RW-VW+1){1'b1}}, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};

  logic [4:0] vld_q;
  logic       accept;

  logic signed [VW-1:0]  v1_q [3];
  logic signed [VW-1:0]  v2_q [3];
  logic signed [VW-1:0]  v3_q [3];
  logic signed [VW-1:0]  v4_q [3];
  logic signed [QW-1:0]  q1_q [3];
  logic signed [QW-1:0]  q2_q [3];
  logic [3:0]            zero_q;
  logic [3:0]            ident_q;

  logic signed [P1W-1:0] p1_d [9];
  logic signed [P1W-1:0] p1_q [9];
  logic signed [P1W-1:0] sh1  [9];
  logic [TW-1:0]         t_d  [3];
  logic signed [TW-1:0]  t_q  [3];
  logic signed [P2W-1:0] p2_d [6];
  logic signed [P2W-1:0] p2_q [6];
  logic signed [P2W-1:0] sh2  [6];
  logic signed [RW-1:0]  r_d  [3];
  logic signed [RW-1:0]  r_q  [3];
  logic signed [VW-1:0]  c_d  [3];
  logic [2:0]            sat_d;
  logic signed [32:0]    qw_ext;
  logic                  zero_d;
  logic                  ident_d;
  qvr_out_t              out_d;
  qvr_out_t              out_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    qw_ext  = 33'(cmd_i.quat_w);
    zero_d  = (cmd_i.vec_x == '0) && (cmd_i.vec_y == '0) && (cmd_i.vec_z == '0);
    ident_d = (qw_ext == QOne) && (cmd_i.quat_x == '0) && (cmd_i.quat_y == '0) &&
              (cmd_i.quat_z == '0);
    p1_d[0] = P1W'(cmd_i.quat_w) * P1W'(cmd_i.vec_x);
    p1_d[1] = P1W'(cmd_i.quat_y) * P1W'(cmd_i.vec_z);
    p1_d[2] = P1W'(cmd_i.quat_z) * P1W'(cmd_i.vec_y);
    p1_d[3] = P1W'(cmd_i.quat_w) * P1W'(cmd_i.vec_y);
    p1_d[4] = P1W'(cmd_i.quat_z) * P1W'(cmd_i.vec_x);
    p1_d[5] = P1W'(cmd_i.quat_x) * P1W'(cmd_i.vec_z);
    p1_d[6] = P1W'(cmd_i.quat_w) * P1W'(cmd_i.vec_z);
    p1_d[7] = P1W'(cmd_i.quat_x) * P1W'(cmd_i.vec_y);
    p1_d[8] = P1W'(cmd_i.quat_y) * P1W'(cmd_i.vec_x);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      sh1[i] = p1_q[i] >>> F;
    end
    for (int i = 0; i < 3; i++) begin
      t_d[i] = sh1[3*i][TW-1:0] + sh1[3*i+1][TW-1:0] - sh1[3*i+2][TW-1:0];
    end
  end

  always_comb begin
    p2_d[0] = P2W'(q2_q[1]) * P2W'(t_q[2]);
    p2_d[1] = P2W'(q2_q[2]) * P2W'(t_q[1]);
    p2_d[2] = P2W'(q2_q[2]) * P2W'(t_q[0]);
    p2_d[3] = P2W'(q2_q[0]) * P2W'(t_q[2]);
    p2_d[4] = P2W'(q2_q[0]) * P2W'(t_q[1]);
    p2_d[5] = P2W'(q2_q[1]) * P2W'(t_q[0]);
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sh2[i] = p2_q[i] >>> F;
    end
    for (int i = 0; i < 3; i++) begin
      r_d[i] = RW'(v3_q[i]) + ((RW'(sh2[2*i]) - RW'(sh2[2*i+1])) <<< 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_d[i] = 1'b0;
      if (r_q[i] > RMax) begin
        c_d[i]   = VMax;
        sat_d[i] = 1'b1;
      end else if (r_q[i] < RMin) begin
        c_d[i]   = VMin;
        sat_d[i] = 1'b1;
      end else begin
        c_d[i] = r_q[i][VW-1:0];
      end
    end
    priority if (zero_q[3]) begin
      out_d = '0;
    end else if (ident_q[3]) begin
      out_d.rot_x     = v4_q[0];
      out_d.rot_y     = v4_q[1];
      out_d.rot_z     = v4_q[2];
      out_d.saturated = 1'b0;
    end else begin
      out_d.rot_x     = c_d[0];
      out_d.rot_y     = c_d[1];
      out_d.rot_z     = c_d[2];
      out_d.saturated = |sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q       <= p1_d;
    v1_q[0]    <= cmd_i.vec_x;
    v1_q[1]    <= cmd_i.vec_y;
    v1_q[2]    <= cmd_i.vec_z;
    q1_q[0]    <= cmd_i.quat_x;
    q1_q[1]    <= cmd_i.quat_y;
    q1_q[2]    <= cmd_i.quat_z;
    zero_q[0]  <= zero_d;
    ident_q[0] <= ident_d;
    for (int i = 0; i < 3; i++) begin
      t_q[i] <= t_d[i];
    end
    v2_q       <= v1_q;
    q2_q       <= q1_q;
    p2_q       <= p2_d;
    v3_q       <= v2_q;
    r_q        <= r_d;
    v4_q       <= v3_q;
    zero_q[3:1]  <= zero_q[2:0];
    ident_q[3:1] <= ident_q[2:0];
    out_q      <= out_d;
  end

  assign done_o   = vld_q[4];
  assign result_o = out_q;

  `QVR_ASSERT_IMPL(a_latency, accept, ##5 done_o)
  `QVR_ASSERT_IMPL(a_zero_vec,
                   accept && (cmd_i.vec_x == '0) && (cmd_i.vec_y == '0) && (cmd_i.vec_z == '0),
                   ##5 (result_o == '0))
  `QVR_ASSERT_IMPL(a_identity,
                   accept && (33'(cmd_i.quat_w) == QOne) && (cmd_i.quat_x == '0) &&
                   (cmd_i.quat_y == '0) && (cmd_i.quat_z == '0),
                   ##5 ((result_o.rot_x == $past(cmd_i.vec_x, 5)) &&
                        (result_o.rot_y == $past(cmd_i.vec_y, 5)) &&
                        (result_o.rot_z == $past(cmd_i.vec_z, 5)) && !result_o.saturated))
  `QVR_ASSERT_IMPL(a_sat_clamped, done_o && result_o.saturated,
                   (result_o.rot_x == VMax) || (result_o.rot_x == VMin) ||
                   (result_o.rot_y == VMax) || (result_o.rot_y == VMin) ||
                   (result_o.rot_z == VMax) || (result_o.rot_z == VMin))

endmodule
